### rtl/bleack_pkg.sv
`default_nettype none

package bleack_pkg;

    localparam int QUEUE_DEPTH = 8;

    localparam int CMD_W   = 2;
    localparam int COUNT_W = 4;
    localparam int TIMER_W = 16;
    localparam int EVCNT_W = 16;
    localparam int CFG_W   = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_EVENT_START = 2'd0,
        CMD_PACKET_RX   = 2'd1,
        CMD_REPLY_SENT  = 2'd2,
        CMD_RX_TIMEOUT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_LISTEN = 2'd1,
        ACT_CLOSE  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SEL_RESEND = 2'd0,
        SEL_NEXT   = 2'd1,
        SEL_EMPTY  = 2'd2
    } tx_sel_t;

    localparam logic REG_WINDOW_TIMEOUT = 1'b0;
    localparam logic REG_RX_TIMEOUT     = 1'b1;

    localparam logic [CFG_W-1:0]   WINDOW_TIMEOUT_RST = 16'd1250;
    localparam logic [CFG_W-1:0]   RX_TIMEOUT_RST     = 16'd500;
    localparam logic [EVCNT_W-1:0] EVCNT_RST          = 16'hFFFF;

    typedef struct packed {
        logic               rx_buffer_ok;
        logic [COUNT_W-1:0] tx_queue_count;
        logic               payload_nonempty;
        logic               crc_ok;
        logic               rx_md;
        logic               rx_nesn;
        logic               rx_sn;
    } rx_event_t;

    typedef struct packed {
        logic [EVCNT_W-1:0] event_count;
        logic               refresh_supervision;
        logic [TIMER_W-1:0] rx_timer_value;
        logic               reply_md;
        logic               reply_nesn;
        logic               reply_sn;
        tx_sel_t            tx_select;
        logic               deliver_payload;
    } reply_t;

endpackage

`default_nettype wire

### rtl/ble_ll_ack_flow_control.sv
`default_nettype none

// Channel   | Direction | tdata (low bit up)                              | tuser
// s_axis_*  | in        | rx_sn, rx_nesn, rx_md, crc_ok, payload_nonempty, | command
//           |           | tx_queue_count[3:0], rx_buffer_ok, zero pad     |
// m_axis_*  | out       | deliver_payload, tx_select[1:0], reply_sn,      | action
//           |           | reply_nesn, reply_md, rx_timer_value[15:0],     |
//           |           | refresh_supervision, event_count[15:0], pad     |
// cfg_*     | in        | index 0 window_timeout, index 1 rx_timeout      | -
//
// One event per cycle unless stalled; m_axis_tvalid rises as the output register loads.
// The input register takes a beat while a finished result waits in the output register.
// Stalls on m_axis_tready back up through the input register to s_axis_tready.
// aresetn is synchronous, active low; it resets link state, timeouts and both valid flags.

module ble_ll_ack_flow_control (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // rx_sn, rx_nesn, rx_md, crc_ok, payload_nonempty, tx_queue_count, rx_buffer_ok
    input  wire  [bleack_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command
    input  wire  [bleack_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // deliver_payload, tx_select, reply_sn, reply_nesn, reply_md, rx_timer_value,
    // refresh_supervision, event_count
    output logic [bleack_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // action
    output logic [1:0]                          m_axis_tuser,
    input  wire                                 cfg_wr_en,
    input  wire                                 cfg_index,
    input  wire  [bleack_pkg::CFG_W-1:0]        cfg_wr_data
);
    import bleack_pkg::*;

    localparam int REPLY_W = $bits(reply_t);
    localparam int EVENT_W = $bits(rx_event_t);

    logic                 in_valid_reg;
    cmd_t                 in_cmd_reg;
    rx_event_t            in_evt_reg;

    logic                 out_valid_reg;
    action_t              out_action_reg;
    reply_t               out_reply_reg;

    logic [CFG_W-1:0]     window_timeout_reg;
    logic [CFG_W-1:0]     rx_timeout_reg;

    logic                 local_sn_reg, local_sn_next;
    logic                 local_nesn_reg, local_nesn_next;
    logic                 anchored_reg, anchored_next;
    logic                 more_data_reg, more_data_next;
    logic                 short_timeout_reg, short_timeout_next;
    logic [EVCNT_W-1:0]   event_counter_reg, event_counter_next;

    action_t              action_next;
    reply_t               reply_next;

    logic                 out_free;
    logic                 advance;
    logic [COUNT_W-1:0]   count_sat;
    logic [COUNT_W-1:0]   remaining;
    logic [TIMER_W-1:0]   cur_timeout;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - REPLY_W){1'b0}}, out_reply_reg};

    assign cur_timeout = short_timeout_reg ? rx_timeout_reg : window_timeout_reg;

    always_comb begin
        if (int'(in_evt_reg.tx_queue_count) > QUEUE_DEPTH) begin
            count_sat = COUNT_W'(QUEUE_DEPTH);
        end else begin
            count_sat = in_evt_reg.tx_queue_count;
        end
    end

    always_comb begin
        local_sn_next      = local_sn_reg;
        local_nesn_next    = local_nesn_reg;
        anchored_next      = anchored_reg;
        more_data_next     = more_data_reg;
        short_timeout_next = short_timeout_reg;
        event_counter_next = event_counter_reg;
        remaining          = count_sat;
        action_next        = ACT_CLOSE;
        reply_next         = '0;
        reply_next.tx_select = SEL_RESEND;

        unique case (in_cmd_reg)
            CMD_EVENT_START: begin
                event_counter_next = event_counter_reg + EVCNT_W'(1);
                if (in_evt_reg.rx_buffer_ok) begin
                    anchored_next             = 1'b0;
                    action_next               = ACT_LISTEN;
                    reply_next.rx_timer_value = cur_timeout;
                end
            end
            CMD_PACKET_RX: begin
                anchored_next      = 1'b1;
                if (!anchored_reg) begin
                    short_timeout_next = 1'b1;
                end
                if ((in_evt_reg.rx_sn == local_nesn_reg) && in_evt_reg.crc_ok) begin
                    reply_next.deliver_payload = in_evt_reg.payload_nonempty;
                    local_nesn_next            = !local_nesn_reg;
                end
                if (local_sn_reg != in_evt_reg.rx_nesn) begin
                    local_sn_next = !local_sn_reg;
                    if (count_sat != '0) begin
                        reply_next.tx_select = SEL_NEXT;
                        remaining            = count_sat - COUNT_W'(1);
                    end else begin
                        reply_next.tx_select = SEL_EMPTY;
                    end
                end
                reply_next.reply_md = (remaining != '0);
                if ((remaining != '0) || in_evt_reg.rx_md) begin
                    more_data_next = 1'b1;
                end
                reply_next.reply_sn            = local_sn_next;
                reply_next.reply_nesn          = local_nesn_next;
                reply_next.refresh_supervision = 1'b1;
                action_next                    = ACT_SEND;
            end
            CMD_REPLY_SENT: begin
                if (in_evt_reg.rx_buffer_ok && more_data_reg) begin
                    more_data_next            = 1'b0;
                    action_next               = ACT_LISTEN;
                    reply_next.rx_timer_value = cur_timeout;
                end
            end
            CMD_RX_TIMEOUT: begin
                action_next = ACT_CLOSE;
            end
            default: begin
                action_next = ACT_CLOSE;
            end
        endcase

        reply_next.event_count = event_counter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            window_timeout_reg <= WINDOW_TIMEOUT_RST;
            rx_timeout_reg     <= RX_TIMEOUT_RST;
            local_sn_reg       <= 1'b1;
            local_nesn_reg     <= 1'b0;
            anchored_reg       <= 1'b0;
            more_data_reg      <= 1'b0;
            short_timeout_reg  <= 1'b0;
            event_counter_reg  <= EVCNT_RST;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WINDOW_TIMEOUT: window_timeout_reg <= cfg_wr_data;
                    REG_RX_TIMEOUT:     rx_timeout_reg     <= cfg_wr_data;
                    default:            window_timeout_reg <= window_timeout_reg;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg     <= 1'b1;
                local_sn_reg      <= local_sn_next;
                local_nesn_reg    <= local_nesn_next;
                anchored_reg      <= anchored_next;
                more_data_reg     <= more_data_next;
                short_timeout_reg <= short_timeout_next;
                event_counter_reg <= event_counter_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_evt_reg <= rx_event_t'(s_axis_tdata[EVENT_W-1:0]);
        end
        if (advance) begin
            out_action_reg <= action_next;
            out_reply_reg  <= reply_next;
        end
    end

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (local_sn_reg && !local_nesn_reg && (event_counter_reg == EVCNT_RST)))
        else $error("link state not at reset values after reset");

    a_send_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_action_reg == ACT_SEND)) |-> out_reply_reg.refresh_supervision)
        else $error("reply without supervision refresh");

    a_timer_only_listen: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_action_reg != ACT_LISTEN)) |-> (out_reply_reg.rx_timer_value == '0))
        else $error("receive timer armed without listen");

    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg == CMD_EVENT_START))
        |=> (event_counter_reg == $past(event_counter_reg) + EVCNT_W'(1)))
        else $error("event counter did not advance on event start");

    a_counter_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg != CMD_EVENT_START)) |=> $stable(event_counter_reg))
        else $error("event counter moved without event start");

endmodule

`default_nettype wire

### test/tb_ble_ll_ack_flow_control.sv
module tb_ble_ll_ack_flow_control;
    timeunit 1ns;
    timeprecision 1ps;

    import bleack_pkg::*;

    typedef struct {
        cmd_t      cmd;
        rx_event_t hdr;
    } ll_event_t;

    typedef struct {
        action_t act;
        reply_t  fields;
    } ll_reply_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]     s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_wr_en     = 1'b0;
    logic                 cfg_index     = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data   = '0;

    ble_ll_ack_flow_control i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    ll_event_t        pending_events[$];
    ll_reply_t        awaited_replies[$];
    ll_event_t        on_bus;
    ll_reply_t        want;
    reply_t           got_rep;
    int unsigned      events_pushed = 0;
    int unsigned      replies_seen  = 0;
    int unsigned      errors        = 0;
    int unsigned      s_gap         = 0;
    int unsigned      m_stall       = 0;
    bit               s_idle_on     = 1'b0;
    bit               m_idle_on     = 1'b0;

    // link state mirror
    logic             link_sn;
    logic             link_nesn;
    logic             link_anchored;
    logic             link_more_data;
    logic             link_short_to;
    logic [EVCNT_W-1:0] link_evcnt;
    logic [CFG_W-1:0] window_to;
    logic [CFG_W-1:0] rx_to;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic predict_reply(input ll_event_t ev);
        ll_reply_t          res;
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0] left;
        logic [TIMER_W-1:0] tmo;
        res.act    = ACT_CLOSE;
        res.fields = '0;
        cnt = ev.hdr.tx_queue_count;
        if (cnt > QUEUE_DEPTH)
            cnt = COUNT_W'(QUEUE_DEPTH);
        tmo = link_short_to ? rx_to : window_to;
        case (ev.cmd)
            CMD_EVENT_START: begin
                link_evcnt = link_evcnt + 1'b1;
                if (ev.hdr.rx_buffer_ok) begin
                    link_anchored = 1'b0;
                    res.act = ACT_LISTEN;
                    res.fields.rx_timer_value = tmo;
                end
            end
            CMD_PACKET_RX: begin
                left = cnt;
                if (!link_anchored) begin
                    link_anchored = 1'b1;
                    link_short_to = 1'b1;
                end
                if (ev.hdr.rx_sn == link_nesn && ev.hdr.crc_ok) begin
                    res.fields.deliver_payload = ev.hdr.payload_nonempty;
                    link_nesn = ~link_nesn;
                end
                if (link_sn != ev.hdr.rx_nesn) begin
                    link_sn = ~link_sn;
                    if (cnt != 0) begin
                        res.fields.tx_select = SEL_NEXT;
                        left = cnt - 1'b1;
                    end else begin
                        res.fields.tx_select = SEL_EMPTY;
                    end
                end else begin
                    res.fields.tx_select = SEL_RESEND;
                end
                res.fields.reply_md = (left != 0);
                if (res.fields.reply_md || ev.hdr.rx_md)
                    link_more_data = 1'b1;
                res.fields.reply_sn            = link_sn;
                res.fields.reply_nesn          = link_nesn;
                res.fields.refresh_supervision = 1'b1;
                res.act = ACT_SEND;
            end
            CMD_REPLY_SENT: begin
                if (ev.hdr.rx_buffer_ok && link_more_data) begin
                    link_more_data = 1'b0;
                    res.act = ACT_LISTEN;
                    res.fields.rx_timer_value = tmo;
                end
            end
            default: begin
            end
        endcase
        res.fields.event_count = link_evcnt;
        awaited_replies.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                predict_reply(on_bus);
            if (s_gap != 0) begin
                s_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                on_bus = pending_events.pop_front();
                s_axis_tdata  <= S_TDATA_W'(on_bus.hdr);
                s_axis_tuser  <= on_bus.cmd;
                s_axis_tvalid <= 1'b1;
                s_gap = s_idle_on ? pick_gap() : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_rep = reply_t'(m_axis_tdata[$bits(reply_t)-1:0]);
                if (awaited_replies.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: action %0d data %h", m_axis_tuser, got_rep);
                end else begin
                    want = awaited_replies.pop_front();
                    replies_seen++;
                    if (m_axis_tuser !== want.act
                        || got_rep.deliver_payload !== want.fields.deliver_payload
                        || got_rep.tx_select !== want.fields.tx_select
                        || got_rep.reply_sn !== want.fields.reply_sn
                        || got_rep.reply_nesn !== want.fields.reply_nesn
                        || got_rep.reply_md !== want.fields.reply_md
                        || got_rep.rx_timer_value !== want.fields.rx_timer_value
                        || got_rep.refresh_supervision !== want.fields.refresh_supervision
                        || got_rep.event_count !== want.fields.event_count) begin
                        errors++;
                        if (errors <= 10)
                            $display("beat %0d: expected action %0d data %h, got action %0d data %h",
                                     replies_seen, want.act, want.fields, m_axis_tuser, got_rep);
                    end
                end
            end
            if (m_stall != 0) begin
                m_stall--;
                m_axis_tready <= 1'b0;
            end else if (m_idle_on && $urandom_range(0, 4) == 0) begin
                m_stall = pick_gap();
                m_axis_tready <= (m_stall == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic rx_event_t make_hdr(input logic sn, input logic nesn, input logic md,
                                           input logic crc, input logic nonempty,
                                           input logic [COUNT_W-1:0] cnt, input logic rxbuf);
        rx_event_t h;
        h.rx_sn            = sn;
        h.rx_nesn          = nesn;
        h.rx_md            = md;
        h.crc_ok           = crc;
        h.payload_nonempty = nonempty;
        h.tx_queue_count   = cnt;
        h.rx_buffer_ok     = rxbuf;
        return h;
    endfunction

    function automatic rx_event_t random_hdr();
        logic [COUNT_W-1:0] cnt;
        cnt = ($urandom_range(0, 9) < 7) ? COUNT_W'($urandom_range(0, QUEUE_DEPTH))
                                         : COUNT_W'($urandom_range(0, 15));
        return make_hdr(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), $urandom_range(0, 99) < 85,
                        1'($urandom_range(0, 1)), cnt, $urandom_range(0, 99) < 85);
    endfunction

    task automatic push_event(input cmd_t cmd, input rx_event_t hdr);
        ll_event_t ev;
        ev.cmd = cmd;
        ev.hdr = hdr;
        pending_events.push_back(ev);
        events_pushed++;
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (replies_seen != events_pushed);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == REG_WINDOW_TIMEOUT)
            window_to = val;
        else
            rx_to = val;
    endtask

    // connection events: start, then packet and reply pairs, sometimes a timeout; else one random command
    task automatic queue_traffic(input int unsigned n);
        int unsigned made;
        int unsigned pairs;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 9) < 8) begin
                push_event(CMD_EVENT_START, random_hdr());
                made++;
                pairs = $urandom_range(1, 6);
                repeat (pairs) begin
                    push_event(CMD_PACKET_RX, random_hdr());
                    push_event(CMD_REPLY_SENT, random_hdr());
                    made += 2;
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_event(CMD_RX_TIMEOUT, random_hdr());
                    made++;
                end
            end else begin
                push_event(cmd_t'($urandom_range(0, 3)), random_hdr());
                made++;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] win_val;
        logic [CFG_W-1:0] rxt_val;
        link_sn        = 1'b1;
        link_nesn      = 1'b0;
        link_anchored  = 1'b0;
        link_more_data = 1'b0;
        link_short_to  = 1'b0;
        link_evcnt     = EVCNT_RST;
        window_to      = WINDOW_TIMEOUT_RST;
        rx_to          = RX_TIMEOUT_RST;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // window timeout is only visible before the first packet anchors
        push_event(CMD_EVENT_START, make_hdr(0, 0, 0, 0, 0, 0, 1));
        wait_drained();
        write_reg(REG_WINDOW_TIMEOUT, '0);
        push_event(CMD_EVENT_START, make_hdr(0, 0, 0, 0, 0, 0, 1));
        wait_drained();
        write_reg(REG_WINDOW_TIMEOUT, '1);
        write_reg(REG_RX_TIMEOUT, '0);
        push_event(CMD_EVENT_START, make_hdr(1, 1, 1, 1, 1, 15, 1));
        push_event(CMD_EVENT_START, make_hdr(0, 0, 0, 0, 0, 0, 0));
        push_event(CMD_RX_TIMEOUT,  make_hdr(1, 1, 1, 1, 1, 15, 1));
        push_event(CMD_REPLY_SENT,  make_hdr(0, 0, 0, 0, 0, 0, 1));
        push_event(CMD_PACKET_RX,   make_hdr(0, 0, 0, 1, 1, 0, 1));
        push_event(CMD_REPLY_SENT,  make_hdr(0, 0, 0, 0, 0, 0, 1));
        push_event(CMD_PACKET_RX,   make_hdr(1, 1, 1, 1, 0, 8, 1));
        push_event(CMD_REPLY_SENT,  make_hdr(0, 0, 0, 0, 0, 0, 0));
        push_event(CMD_REPLY_SENT,  make_hdr(0, 0, 0, 0, 0, 0, 1));
        push_event(CMD_PACKET_RX,   make_hdr(0, 1, 0, 0, 1, 15, 0));
        push_event(CMD_PACKET_RX,   make_hdr(1, 0, 0, 1, 1, 9, 1));
        push_event(CMD_PACKET_RX,   make_hdr(0, 0, 0, 1, 1, 1, 1));
        push_event(CMD_EVENT_START, make_hdr(0, 0, 0, 0, 0, 0, 1));
        push_event(CMD_EVENT_START, make_hdr(1, 1, 1, 1, 1, 15, 0));
        push_event(CMD_PACKET_RX,   make_hdr(1, 1, 1, 1, 1, 15, 1));
        push_event(CMD_REPLY_SENT,  make_hdr(1, 1, 1, 1, 1, 15, 1));
        push_event(CMD_RX_TIMEOUT,  make_hdr(0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    win_val = '0;
                    rxt_val = '0;
                end
                1: begin
                    win_val = '1;
                    rxt_val = '1;
                end
                3: begin
                    win_val = 16'd1;
                    rxt_val = 16'hFFFE;
                end
                5: begin
                    win_val = '1;
                    rxt_val = '0;
                end
                7: begin
                    win_val = '0;
                    rxt_val = '1;
                end
                default: begin
                    win_val = CFG_W'($urandom);
                    rxt_val = CFG_W'($urandom);
                end
            endcase
            write_reg(REG_WINDOW_TIMEOUT, win_val);
            write_reg(REG_RX_TIMEOUT, rxt_val);
            s_idle_on = (p == 1) || (p >= 3);
            m_idle_on = (p == 2) || (p >= 3);
            queue_traffic(235);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        errors += awaited_replies.size();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
